// ===== rtl/core/dfw_pkg.sv =====
package dfw_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = 6;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int DEPTH_W      = $clog2(MAX_VERTICES + 1);

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD      = 2'd1,
    OP_TRAVERSE = 2'd2,
    OP_RESERVED = 2'd3
  } dfw_op_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // take the input request this cycle
    logic step;    // advance the walk by one push or pop
    logic finish;  // emit the held vertex as the final result
  } dfw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_ok;  // input is a traverse with a valid start
    logic walk_end;  // next step pops the start vertex
    logic out_free;  // output register can take a result
  } dfw_sts_t;

  // Index of the lowest set bit; zero when none is set
  function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_VERTICES-1:0] x);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/core/dfw_ctrl.sv =====
module dfw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dfw_pkg::dfw_sts_t sts,
  output dfw_pkg::dfw_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } dfw_state_t;

  dfw_state_t state_r, state_nxt;

  assign in_stall   = !((state_r == S_IDLE) && sts.out_free);
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.step   = (state_r == S_WALK);
  assign cmd.finish = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && sts.start_ok) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_end) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/core/dfw_datapath.sv =====
module dfw_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dfw_pkg::VTX_W-1:0]  cfg_wr_data,
  input  logic [1:0]                 in_operation,
  input  logic [dfw_pkg::VTX_W-1:0]  in_src_vertex,
  input  logic [dfw_pkg::VTX_W-1:0]  in_dst_vertex,
  input  dfw_pkg::dfw_cmd_t          cmd,
  output dfw_pkg::dfw_sts_t          sts,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [dfw_pkg::VTX_W-1:0]  out_vertex,
  output logic                       out_last
);

  localparam int MAXV = dfw_pkg::MAX_VERTICES;
  localparam int VW   = dfw_pkg::VTX_W;
  localparam int IW   = dfw_pkg::IDX_W;
  localparam int DW   = dfw_pkg::DEPTH_W;

  logic [VW-1:0]   vcount_r;
  logic [MAXV-1:0] adj_r [MAXV];
  logic [MAXV-1:0] visited_r;
  logic [VW-1:0]   stack_r [MAXV];
  logic [DW-1:0]   depth_r;
  logic [VW-1:0]   top_r;
  logic [VW-1:0]   pend_r;
  logic            out_valid_r, out_valid_nxt;
  logic [VW-1:0]   out_vertex_r;
  logic            out_last_r;

  logic [VW-1:0]   n_eff;
  logic            src_ok, dst_ok;
  logic [MAXV:0]   live_ext;
  logic [MAXV-1:0] live, cand;
  logic [VW-1:0]   src_m1, dst_m1, top_m1;
  logic [DW-1:0]   depth_m2;
  logic [IW-1:0]   cand_bit;
  logic [VW-1:0]   new_v;
  logic            can_push, do_push, do_pop, out_free;
  logic            is_trav, ld_invalid, ld_push, ld_final;

  assign n_eff  = (vcount_r > VW'(MAXV)) ? VW'(MAXV) : vcount_r;
  assign src_ok = (in_src_vertex != '0) && (in_src_vertex <= n_eff);
  assign dst_ok = (in_dst_vertex != '0) && (in_dst_vertex <= n_eff);
  assign src_m1 = in_src_vertex - VW'(1);
  assign dst_m1 = in_dst_vertex - VW'(1);
  assign top_m1 = top_r - VW'(1);
  assign depth_m2 = depth_r - DW'(2);

  assign live_ext = ({{MAXV{1'b0}}, 1'b1} << n_eff) - (MAXV+1)'(1);
  assign live     = live_ext[MAXV-1:0];
  assign cand     = adj_r[top_m1[IW-1:0]] & live & ~visited_r;
  assign can_push = (|cand) && (depth_r < DW'(MAXV));
  assign cand_bit = dfw_pkg::lowest_set(cand);
  assign new_v    = VW'(cand_bit) + VW'(1);

  assign out_free = !out_valid_r || !out_stall;
  assign do_push  = cmd.step && can_push && out_free;
  assign do_pop   = cmd.step && !can_push;
  assign is_trav  = (in_operation == dfw_pkg::OP_TRAVERSE);

  assign ld_invalid = cmd.accept && is_trav && !src_ok;
  assign ld_push    = do_push;
  assign ld_final   = cmd.finish && out_free;

  assign sts.start_ok = is_trav && src_ok;
  assign sts.walk_end = !can_push && (depth_r == DW'(1));
  assign sts.out_free = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= VW'(MAXV);
    else if (cfg_wr_en) vcount_r <= cfg_wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAXV; i++) adj_r[i] <= '0;
    end else if (cmd.accept) begin
      case (in_operation)
        dfw_pkg::OP_CLEAR: begin
          for (int i = 0; i < MAXV; i++) adj_r[i] <= '0;
        end
        dfw_pkg::OP_ADD: begin
          if (src_ok && dst_ok) adj_r[src_m1[IW-1:0]][dst_m1[IW-1:0]] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
      depth_r   <= '0;
    end else if (cmd.accept && is_trav && src_ok) begin
      visited_r <= MAXV'(1) << src_m1[IW-1:0];
      depth_r   <= DW'(1);
    end else if (do_push) begin
      visited_r[cand_bit] <= 1'b1;
      depth_r <= depth_r + DW'(1);
    end else if (do_pop) begin
      depth_r <= depth_r - DW'(1);
    end
  end

  // Path stack, top register and held vertex
  always_ff @(posedge clk) begin
    if (cmd.accept && is_trav && src_ok) begin
      stack_r[0] <= in_src_vertex;
      top_r      <= in_src_vertex;
      pend_r     <= in_src_vertex;
    end else if (do_push) begin
      stack_r[depth_r[IW-1:0]] <= new_v;
      top_r  <= new_v;
      pend_r <= new_v;
    end else if (do_pop) begin
      top_r <= stack_r[depth_m2[IW-1:0]];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ld_invalid || ld_push || ld_final) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (ld_invalid) begin
      out_vertex_r <= '0;
      out_last_r   <= 1'b1;
    end else if (ld_push || ld_final) begin
      out_vertex_r <= pend_r;
      out_last_r   <= ld_final;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;

`ifndef NO_ASSERTIONS
  a_push_depth: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> depth_r == $past(depth_r) + DW'(1))
    else $error("depth did not advance on push");

  a_top_visited: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> visited_r[top_m1[IW-1:0]])
    else $error("top of path not marked visited");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (depth_r != '0) && (depth_r <= DW'(MAXV)))
    else $error("path depth out of bounds during walk");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(ld_invalid || ld_push || ld_final))
    else $error("result loaded over a stalled result");
`endif

endmodule

// ===== rtl/core/graph_depth_first_walk.sv =====
// Depth-first walk over a directed graph of up to 32 vertices held as a
// 32x32 adjacency bit matrix in flops. Clear requests empty the matrix and
// add-edge requests set one bit when both vertices are in range; one request
// is taken per cycle while input is not stalled. A traverse request walks
// from the start vertex, always taking the lowest-numbered unvisited
// successor, and returns the visited vertices in order with last set on the
// final one (a start outside 1..vertex_count gives a single result of vertex
// 0 with last set). A traverse is accepted, then walked by stack pushes and
// pops, and then its final result is released; the walk stepper does one push
// or pop per cycle unless output stall holds a push, and holds input stalled
// until done. Output stall pauses pushes. Write vertex_count only while idle.
module graph_depth_first_walk (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [dfw_pkg::VTX_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_operation,
  input  logic [dfw_pkg::VTX_W-1:0] in_src_vertex,
  input  logic [dfw_pkg::VTX_W-1:0] in_dst_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [dfw_pkg::VTX_W-1:0] out_vertex,
  output logic                      out_last
);

  dfw_pkg::dfw_cmd_t cmd;
  dfw_pkg::dfw_sts_t sts;

  // Sequence accept, walk and final release
  dfw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold matrix, path stack, visited mask and output register
  dfw_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_operation  (in_operation),
    .in_src_vertex (in_src_vertex),
    .in_dst_vertex (in_dst_vertex),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_vertex    (out_vertex),
    .out_last      (out_last)
  );

endmodule
